// ----- sv/acse_pkg.sv -----
package acse_pkg;

    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_INX = 8'hE8;
    localparam logic [7:0] OP_INY = 8'hC8;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_DEY = 8'h88;
    localparam logic [7:0] OP_LDA = 8'hA9;
    localparam logic [7:0] OP_LDX = 8'hA2;
    localparam logic [7:0] OP_LDY = 8'hA0;
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_PHA = 8'h48;
    localparam logic [7:0] OP_PLA = 8'h68;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_RTS = 8'h60;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_OVERFLOW    = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [7:0] FLAGS_RESET = 8'h20;
    localparam logic [7:0] SP_RESET    = 8'hFF;

    // instruction classes produced by the front end
    localparam logic [3:0] K_NOP   = 4'd0;
    localparam logic [3:0] K_INX   = 4'd1;
    localparam logic [3:0] K_INY   = 4'd2;
    localparam logic [3:0] K_DEX   = 4'd3;
    localparam logic [3:0] K_DEY   = 4'd4;
    localparam logic [3:0] K_LDA   = 4'd5;
    localparam logic [3:0] K_LDX   = 4'd6;
    localparam logic [3:0] K_LDY   = 4'd7;
    localparam logic [3:0] K_TAX   = 4'd8;
    localparam logic [3:0] K_TAY   = 4'd9;
    localparam logic [3:0] K_TXA   = 4'd10;
    localparam logic [3:0] K_TYA   = 4'd11;
    localparam logic [3:0] K_TSX   = 4'd12;
    localparam logic [3:0] K_PHA   = 4'd13;
    localparam logic [3:0] K_PLA   = 4'd14;
    localparam logic [3:0] K_OTHER = 4'd15;

    typedef struct packed {
        logic [3:0] kind;
        logic       jsr;
        logic       rts;
        logic [7:0] lo;
        logic [7:0] hi;
    } dec_t;

endpackage

// ----- sv/acse_ram.sv -----
module acse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/acse_front.sv -----
module acse_front
    import acse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_opcode,
    input  logic [7:0] s_operand_low,
    input  logic [7:0] s_operand_high,
    output logic       q_valid,
    input  logic       q_ready,
    output dec_t       q_data
);
    // two-entry decoded instruction queue
    dec_t       ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    dec_t       dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec = '0;
        dec.lo = s_operand_low;
        dec.hi = s_operand_high;
        case (s_opcode)
            OP_NOP:  dec.kind = K_NOP;
            OP_INX:  dec.kind = K_INX;
            OP_INY:  dec.kind = K_INY;
            OP_DEX:  dec.kind = K_DEX;
            OP_DEY:  dec.kind = K_DEY;
            OP_LDA:  dec.kind = K_LDA;
            OP_LDX:  dec.kind = K_LDX;
            OP_LDY:  dec.kind = K_LDY;
            OP_TAX:  dec.kind = K_TAX;
            OP_TAY:  dec.kind = K_TAY;
            OP_TXA:  dec.kind = K_TXA;
            OP_TYA:  dec.kind = K_TYA;
            OP_TSX:  dec.kind = K_TSX;
            OP_PHA:  dec.kind = K_PHA;
            OP_PLA:  dec.kind = K_PLA;
            OP_JSR: begin
                dec.kind = K_OTHER;
                dec.jsr  = 1'b1;
            end
            OP_RTS: begin
                dec.kind = K_OTHER;
                dec.rts  = 1'b1;
            end
            default: dec.kind = K_OTHER;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = ent_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            ent_reg[wr_reg] <= dec;
        end
    end
endmodule

// ----- sv/acse_back.sv -----
module acse_back
    import acse_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  dec_t        q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pc_out,
    output logic [7:0]  m_acc_out,
    output logic [7:0]  m_x_out,
    output logic [7:0]  m_y_out,
    output logic [7:0]  m_sp_out,
    output logic [7:0]  m_flags_out,
    output logic [1:0]  m_status
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // phases of the sequencer
    localparam logic [1:0] PH_RUN  = 2'd0;
    localparam logic [1:0] PH_JSR2 = 2'd1;
    localparam logic [1:0] PH_RD1  = 2'd2;
    localparam logic [1:0] PH_RD2  = 2'd3;

    logic [1:0]    ph_reg, ph_next;
    logic [15:0]   pc_reg, pc_next;
    logic [7:0]    a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0]    sp_reg, sp_next, f_reg, f_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    rlo_reg, rlo_next;
    logic          ov_next;
    logic [1:0]    st_next;
    logic          res_ld;

    logic       we;
    logic [7:0] waddr, wdata, raddr, rdata;

    acse_ram #(.WIDTH(8), .DEPTH(256)) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
        nz = (f & 8'h7D) | (v & 8'h80) | ((v == 8'd0) ? 8'h02 : 8'h00);
    endfunction

    function automatic logic [7:0] pc_next_hi(input logic [15:0] p);
        logic [15:0] r;
        r = p + 16'd2;
        pc_next_hi = r[15:8];
    endfunction

    assign ov_next = m_valid && !m_ready;
    assign q_ready = (ph_reg == PH_RUN) && !ov_next;

    always_comb begin
        ph_next  = ph_reg;
        pc_next  = pc_reg;
        a_next   = a_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        f_next   = f_reg;
        cnt_next = cnt_reg;
        lo_next  = lo_reg;
        rlo_next = rlo_reg;
        st_next  = ST_OK;
        res_ld   = 1'b0;
        we       = 1'b0;
        waddr    = sp_reg;
        wdata    = a_reg;
        raddr    = sp_reg + 8'd1;
        case (ph_reg)
            PH_RUN: begin
                if (q_valid && q_ready) begin
                    res_ld = 1'b1;
                    case (q_data.kind)
                        K_NOP: pc_next = pc_reg + 16'd1;
                        K_INX: begin
                            x_next = x_reg + 8'd1; f_next = nz(f_reg, x_next);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_INY: begin
                            y_next = y_reg + 8'd1; f_next = nz(f_reg, y_next);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_DEX: begin
                            x_next = x_reg - 8'd1; f_next = nz(f_reg, x_next);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_DEY: begin
                            y_next = y_reg - 8'd1; f_next = nz(f_reg, y_next);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_LDA: begin
                            a_next = q_data.lo; f_next = nz(f_reg, q_data.lo);
                            pc_next = pc_reg + 16'd2;
                        end
                        K_LDX: begin
                            x_next = q_data.lo; f_next = nz(f_reg, q_data.lo);
                            pc_next = pc_reg + 16'd2;
                        end
                        K_LDY: begin
                            y_next = q_data.lo; f_next = nz(f_reg, q_data.lo);
                            pc_next = pc_reg + 16'd2;
                        end
                        K_TAX: begin
                            x_next = a_reg; f_next = nz(f_reg, a_reg);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_TAY: begin
                            y_next = a_reg; f_next = nz(f_reg, a_reg);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_TXA: begin
                            a_next = x_reg; f_next = nz(f_reg, x_reg);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_TYA: begin
                            a_next = y_reg; f_next = nz(f_reg, y_reg);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_TSX: begin
                            x_next = sp_reg; f_next = nz(f_reg, sp_reg);
                            pc_next = pc_reg + 16'd1;
                        end
                        K_PHA: begin
                            if (cnt_reg >= DEPTH_C) begin
                                st_next = ST_OVERFLOW;
                            end else begin
                                we = 1'b1;
                                sp_next = sp_reg - 8'd1;
                                cnt_next = cnt_reg + CW'(1);
                                pc_next = pc_reg + 16'd1;
                            end
                        end
                        K_PLA: begin
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                // result waits for the registered read
                                res_ld = 1'b0;
                                sp_next = sp_reg + 8'd1;
                                cnt_next = cnt_reg - CW'(1);
                                ph_next = PH_RD2;
                                rlo_next = 8'd0;
                                lo_next = 8'd1;
                            end
                        end
                        default: begin
                            if (q_data.jsr) begin
                                if (cnt_reg + CW'(2) > DEPTH_C
                                        || cnt_reg > DEPTH_C - CW'(2)) begin
                                    st_next = ST_OVERFLOW;
                                end else begin
                                    res_ld = 1'b0;
                                    we = 1'b1;
                                    wdata = pc_next_hi(pc_reg);
                                    sp_next = sp_reg - 8'd1;
                                    cnt_next = cnt_reg + CW'(2);
                                    lo_next = pc_reg[7:0] + 8'd2;
                                    pc_next = {q_data.hi, q_data.lo};
                                    ph_next = PH_JSR2;
                                end
                            end else if (q_data.rts) begin
                                if (cnt_reg < CW'(2)) begin
                                    st_next = ST_EMPTY;
                                end else begin
                                    res_ld = 1'b0;
                                    sp_next = sp_reg + 8'd1;
                                    cnt_next = cnt_reg - CW'(2);
                                    ph_next = PH_RD1;
                                end
                            end else begin
                                st_next = ST_UNSUPPORTED;
                            end
                        end
                    endcase
                end
            end
            PH_JSR2: begin
                if (!ov_next) begin
                    we = 1'b1;
                    wdata = lo_reg;
                    sp_next = sp_reg - 8'd1;
                    res_ld = 1'b1;
                    ph_next = PH_RUN;
                end
            end
            PH_RD1: begin
                // low byte arrives, read high byte next
                rlo_next = rdata;
                lo_next = 8'd0;
                sp_next = sp_reg + 8'd1;
                ph_next = PH_RD2;
            end
            default: begin
                if (!ov_next) begin
                    res_ld = 1'b1;
                    ph_next = PH_RUN;
                    if (lo_reg[0]) begin
                        a_next = rdata;
                        f_next = nz(f_reg, rdata);
                        pc_next = pc_reg + 16'd1;
                    end else begin
                        pc_next = {rdata, rlo_reg} + 16'd1;
                    end
                end else begin
                    // hold the read address so the data stays
                    raddr = sp_reg;
                end
            end
        endcase
        if (ph_reg == PH_RD2 || ph_reg == PH_RD1) begin
            raddr = (ph_reg == PH_RD1) ? sp_reg + 8'd1 : sp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= PH_RUN;
            pc_reg  <= 16'd0;
            a_reg   <= 8'd0;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
            sp_reg  <= SP_RESET;
            f_reg   <= FLAGS_RESET;
            cnt_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            ph_reg  <= ph_next;
            pc_reg  <= pc_next;
            a_reg   <= a_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            sp_reg  <= sp_next;
            f_reg   <= f_next;
            cnt_reg <= cnt_next;
            if (res_ld) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
        lo_reg  <= lo_next;
        rlo_reg <= rlo_next;
        if (res_ld) begin
            m_pc_out    <= pc_next;
            m_acc_out   <= a_next;
            m_x_out     <= x_next;
            m_y_out     <= y_next;
            m_sp_out    <= sp_next;
            m_flags_out <= f_next;
            m_status    <= st_next;
        end
    end
endmodule

// ----- sv/accumulator_cpu_subset_executor_core.sv -----
// channel  | ports                                         | direction
// request  | s_valid s_ready s_opcode s_operand_low/high   | in
// result   | m_valid m_ready m_pc_out m_acc_out m_x_out    | out
//          | m_y_out m_sp_out m_flags_out m_status         |
//
// most instructions complete in the back end's run state; jsr and pla need a
// second state, set by the single write port and registered read of the stack ram
// rts passes through states rd1 and rd2 (two dependent stack reads)
// aresetn is synchronous, active low; clears the state registers, stack ram contents
// are left as they are and never read before being written
// a two-entry decoded queue lets the front keep accepting while results stall
module accumulator_cpu_subset_executor_core
    import acse_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_operand_low,
    input  logic [7:0]  s_operand_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pc_out,
    output logic [7:0]  m_acc_out,
    output logic [7:0]  m_x_out,
    output logic [7:0]  m_y_out,
    output logic [7:0]  m_sp_out,
    output logic [7:0]  m_flags_out,
    output logic [1:0]  m_status
);
    // decoded request queue between front and back
    logic q_valid;
    logic q_ready;
    dec_t q_data;

    acse_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_operand_low  (s_operand_low),
        .s_operand_high (s_operand_high),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data)
    );

    // executes against the register file and stack ram
    acse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pc_out    (m_pc_out),
        .m_acc_out   (m_acc_out),
        .m_x_out     (m_x_out),
        .m_y_out     (m_y_out),
        .m_sp_out    (m_sp_out),
        .m_flags_out (m_flags_out),
        .m_status    (m_status)
    );
endmodule

// ----- sv/acse_checker.sv -----
module acse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_flags_out,
    input logic [1:0] m_status
);
    // request held while not accepted
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("request dropped before accept");

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped under stall");

    // only n and z ever move; this checks that bit 5 stays set
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_flags_out[5])
        else $error("flag bit 5 lost");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind accumulator_cpu_subset_executor_core acse_checker u_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_flags_out (m_flags_out),
    .m_status    (m_status)
);

// ----- tb/tb_accumulator_cpu_subset_executor_core.sv -----
`timescale 1ns / 1ps

module tb_accumulator_cpu_subset_executor_core;
    import acse_pkg::*;

    localparam int DEPTH = 256;
    localparam int IDLE_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_opcode = '0;
    logic [7:0]  s_operand_low = '0;
    logic [7:0]  s_operand_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_pc_out;
    logic [7:0]  m_acc_out;
    logic [7:0]  m_x_out;
    logic [7:0]  m_y_out;
    logic [7:0]  m_sp_out;
    logic [7:0]  m_flags_out;
    logic [1:0]  m_status;

    // one expected register snapshot per instruction
    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [1:0]  status;
    } cpu_snapshot_t;

    cpu_snapshot_t pending_snapshots[$];

    // shadow processor state
    logic [15:0] cpu_pc;
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [7:0]  stack_ram [0:255];
    int          stack_fill;

    int errors = 0;
    int sent = 0;
    int checked = 0;
    int idle_cycles = 0;
    bit hold_results = 1'b0;

    accumulator_cpu_subset_executor_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_operand_low(s_operand_low),
        .s_operand_high(s_operand_high),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pc_out(m_pc_out), .m_acc_out(m_acc_out), .m_x_out(m_x_out),
        .m_y_out(m_y_out), .m_sp_out(m_sp_out), .m_flags_out(m_flags_out),
        .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] update_nz(logic [7:0] v);
        cpu_p = (cpu_p & 8'h7D) | (v & 8'h80) | ((v == 8'h00) ? 8'h02 : 8'h00);
        return v;
    endfunction

    function automatic void push_stack(logic [7:0] v);
        stack_ram[cpu_sp] = v;
        cpu_sp = cpu_sp - 8'd1;
        stack_fill++;
    endfunction

    function automatic logic [7:0] pull_stack();
        cpu_sp = cpu_sp + 8'd1;
        stack_fill--;
        return stack_ram[cpu_sp];
    endfunction

    // execute one instruction on the shadow state and queue the snapshot
    function automatic void execute_instruction(logic [7:0] op, logic [7:0] lo,
                                                logic [7:0] hi);
        logic [1:0]  st;
        logic [15:0] ret;
        logic [7:0]  rl, rh;
        cpu_snapshot_t snap;
        st = ST_OK;
        case (op)
            OP_NOP: cpu_pc = cpu_pc + 16'd1;
            OP_INX: begin cpu_x = update_nz(cpu_x + 8'd1); cpu_pc = cpu_pc + 16'd1; end
            OP_INY: begin cpu_y = update_nz(cpu_y + 8'd1); cpu_pc = cpu_pc + 16'd1; end
            OP_DEX: begin cpu_x = update_nz(cpu_x - 8'd1); cpu_pc = cpu_pc + 16'd1; end
            OP_DEY: begin cpu_y = update_nz(cpu_y - 8'd1); cpu_pc = cpu_pc + 16'd1; end
            OP_LDA: begin cpu_a = update_nz(lo); cpu_pc = cpu_pc + 16'd2; end
            OP_LDX: begin cpu_x = update_nz(lo); cpu_pc = cpu_pc + 16'd2; end
            OP_LDY: begin cpu_y = update_nz(lo); cpu_pc = cpu_pc + 16'd2; end
            OP_TAX: begin cpu_x = update_nz(cpu_a); cpu_pc = cpu_pc + 16'd1; end
            OP_TAY: begin cpu_y = update_nz(cpu_a); cpu_pc = cpu_pc + 16'd1; end
            OP_TXA: begin cpu_a = update_nz(cpu_x); cpu_pc = cpu_pc + 16'd1; end
            OP_TYA: begin cpu_a = update_nz(cpu_y); cpu_pc = cpu_pc + 16'd1; end
            OP_TSX: begin cpu_x = update_nz(cpu_sp); cpu_pc = cpu_pc + 16'd1; end
            OP_PHA: begin
                if (stack_fill >= DEPTH) st = ST_OVERFLOW;
                else begin push_stack(cpu_a); cpu_pc = cpu_pc + 16'd1; end
            end
            OP_PLA: begin
                if (stack_fill < 1) st = ST_EMPTY;
                else begin cpu_a = update_nz(pull_stack()); cpu_pc = cpu_pc + 16'd1; end
            end
            OP_JSR: begin
                if (stack_fill + 2 > DEPTH) st = ST_OVERFLOW;
                else begin
                    ret = cpu_pc + 16'd2;
                    push_stack(ret[15:8]);
                    push_stack(ret[7:0]);
                    cpu_pc = {hi, lo};
                end
            end
            OP_RTS: begin
                if (stack_fill < 2) st = ST_EMPTY;
                else begin
                    rl = pull_stack();
                    rh = pull_stack();
                    cpu_pc = {rh, rl} + 16'd1;
                end
            end
            default: st = ST_UNSUPPORTED;
        endcase
        snap = '{cpu_pc, cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, st};
        pending_snapshots.push_back(snap);
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one request, hold it until accepted, predict on acceptance
    // valid stays up after acceptance until a gap or a drain drops it
    task automatic send_instruction(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                                    bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_operand_low <= lo;
        s_operand_high <= hi;
        do @(posedge aclk); while (!s_ready);
        execute_instruction(op, lo, hi);
        sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // result side: random backpressure, or a long hold when requested
    always @(posedge aclk) begin
        if (!aresetn || hold_results) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge aclk) begin
        cpu_snapshot_t e;
        if (aresetn && m_valid && m_ready) begin
            checked++;
            if (pending_snapshots.size() == 0) begin
                $display("%0t unexpected result pc=%h", $time, m_pc_out);
                errors++;
            end else begin
                e = pending_snapshots.pop_front();
                if (m_pc_out !== e.pc) begin
                    $display("%0t pc exp %h got %h", $time, e.pc, m_pc_out); errors++;
                end
                if (m_acc_out !== e.acc) begin
                    $display("%0t acc exp %h got %h", $time, e.acc, m_acc_out); errors++;
                end
                if (m_x_out !== e.x) begin
                    $display("%0t x exp %h got %h", $time, e.x, m_x_out); errors++;
                end
                if (m_y_out !== e.y) begin
                    $display("%0t y exp %h got %h", $time, e.y, m_y_out); errors++;
                end
                if (m_sp_out !== e.sp) begin
                    $display("%0t sp exp %h got %h", $time, e.sp, m_sp_out); errors++;
                end
                if (m_flags_out !== e.flags) begin
                    $display("%0t flags exp %h got %h", $time, e.flags, m_flags_out);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status, m_status);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] random_supported_op();
        logic [7:0] ops [17];
        ops = '{OP_NOP, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_LDA, OP_LDX, OP_LDY,
                OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_PHA, OP_PLA, OP_JSR, OP_RTS};
        return ops[$urandom_range(0, 16)];
    endfunction

    // every opcode at least once, operand extremes, empty-stack pulls and bad opcodes
    task automatic test_directed_opcodes();
        send_instruction(OP_PLA, 8'h00, 8'h00);   // pull from empty stack
        send_instruction(OP_RTS, 8'hFF, 8'hFF);   // return with nothing pushed
        send_instruction(OP_LDA, 8'h00, 8'hFF);   // zero sets z
        send_instruction(OP_LDX, 8'h80, 8'h00);   // bit 7 sets n
        send_instruction(OP_LDY, 8'hFF, 8'h00);
        send_instruction(OP_INY, 8'h00, 8'h00);   // ff wraps to zero
        send_instruction(OP_DEY, 8'h00, 8'h00);
        send_instruction(OP_INX, 8'h00, 8'h00);
        send_instruction(OP_DEX, 8'h00, 8'h00);
        send_instruction(OP_TAX, 8'h00, 8'h00);
        send_instruction(OP_TAY, 8'h00, 8'h00);
        send_instruction(OP_LDX, 8'h7F, 8'h00);
        send_instruction(OP_TXA, 8'h00, 8'h00);
        send_instruction(OP_TYA, 8'h00, 8'h00);
        send_instruction(OP_TSX, 8'h00, 8'h00);   // sp ff -> n set
        send_instruction(OP_NOP, 8'hFF, 8'hFF);
        send_instruction(OP_PHA, 8'h00, 8'h00);
        send_instruction(OP_RTS, 8'h00, 8'h00);   // only one byte held
        send_instruction(OP_PLA, 8'h00, 8'h00);
        send_instruction(OP_JSR, 8'hFE, 8'hFF);   // jump near the top of memory
        send_instruction(OP_RTS, 8'h00, 8'h00);
        send_instruction(OP_JSR, 8'h00, 8'h00);
        send_instruction(OP_RTS, 8'h00, 8'h00);
        send_instruction(8'h00, 8'h00, 8'h00);    // unsupported
        send_instruction(8'hFF, 8'hFF, 8'hFF);
        wait_drained();
    endtask

    // fill the stack completely, overflow both pushes, then drain it
    task automatic test_stack_full_and_empty();
        while (stack_fill < DEPTH - 1)
            send_instruction(OP_PHA, 8'($urandom), 8'($urandom), 1'b1);
        send_instruction(OP_JSR, 8'h34, 8'h12);   // one free byte: overflow
        send_instruction(OP_PHA, 8'h00, 8'h00);
        send_instruction(OP_PHA, 8'h00, 8'h00);   // full: overflow
        send_instruction(OP_TSX, 8'h00, 8'h00);
        while (stack_fill > 0)
            send_instruction(OP_PLA, 8'($urandom), 8'($urandom), 1'b1);
        send_instruction(OP_PLA, 8'h00, 8'h00);
        wait_drained();
    endtask

    // receiver stops for a long time while requests keep coming
    task automatic test_result_backpressure();
        fork
            begin
                hold_results = 1'b1;
                repeat (200) @(posedge aclk);
                hold_results = 1'b0;
            end
            repeat (40) send_instruction(random_supported_op(), 8'($urandom),
                                         8'($urandom), 1'b1);
        join
        wait_drained();
    endtask

    // call/return nests, stack traffic and a little noise
    task automatic test_random_programs();
        int r;
        logic [7:0] op;
        repeat (520) begin
            r = $urandom_range(0, 99);
            if (r < 5) op = 8'($urandom);
            else if (r < 20) op = (stack_fill > 40) ? OP_RTS : OP_JSR;
            else if (r < 30) op = (stack_fill > 40) ? OP_PLA : OP_PHA;
            else op = random_supported_op();
            send_instruction(op, 8'($urandom), 8'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        cpu_pc = '0; cpu_a = '0; cpu_x = '0; cpu_y = '0;
        cpu_sp = SP_RESET; cpu_p = FLAGS_RESET; stack_fill = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_opcodes();
        test_stack_full_and_empty();
        test_result_backpressure();
        test_random_programs();
        repeat (20) @(posedge aclk);
        $display("ran %0d instructions, checked %0d results: all opcodes,", sent, checked);
        $display("stack full/empty limits, bad opcodes and long result stalls");
        if (errors == 0 && pending_snapshots.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
